FILE: src/vpsc_pkg.sv
// shared constants for the length-prefixed string column checker
// parser phases, verdict codes, field widths and register map; no dependencies
package vpsc_pkg;

   // field widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CNT_W   = 21;
   localparam int unsigned CODE_W  = 3;
   localparam int unsigned ACC_W   = 64;
   localparam int unsigned SHIFT_W = 7;
   localparam int unsigned PHASE_W = 2;

   // packed stream words
   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 32;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [0:0]  REG_NULLABLE_MODE = 1'd0;

   // counter ceiling
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // base-128 prefix
   localparam logic [SHIFT_W-1:0] VARINT_STEP  = 7'd7;
   localparam logic [SHIFT_W-1:0] SHIFT_LIMIT  = 7'd64;

   // parser phases
   localparam logic [PHASE_W-1:0] PH_NULLMAP = 2'd0;
   localparam logic [PHASE_W-1:0] PH_PREFIX  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_SKIP    = 2'd2;
   localparam logic [PHASE_W-1:0] PH_DONE    = 2'd3;

   // verdict codes
   localparam logic [CODE_W-1:0] E_OK       = 3'd0;
   localparam logic [CODE_W-1:0] E_NULLMAP  = 3'd1;
   localparam logic [CODE_W-1:0] E_OVERFLOW = 3'd2;
   localparam logic [CODE_W-1:0] E_TOOLONG  = 3'd3;
   localparam logic [CODE_W-1:0] E_TRUNC    = 3'd4;
   localparam logic [CODE_W-1:0] E_NOSTR    = 3'd5;
   localparam logic [CODE_W-1:0] E_SHORT    = 3'd6;

endpackage

FILE: src/varint_prefixed_string_check_unit.sv
// length-prefixed string column checker, top level
// depends on vpsc_pkg for phases, verdict codes and widths
//
// channel | dir | handshake          | payload
// --------+-----+--------------------+-------------------------------------------
// req     | in  | tvalid/tready      | tdata: data_byte, block_length, null_rows;
//         |     |                    | tuser: first_byte; tlast: last_byte
// rsp     | out | tvalid/tready      | tdata: block_ok, error_code, prefix_count
// csr     | in  | apb psel/penable   | reg 0 at byte address 0: nullable_mode
//
// one byte per cycle sustained, unless a byte carrying a verdict meets a held verdict;
// a verdict reaches rsp through the input register, then the result register
// the parser state update (prefix or, length compare, counters) is the one
// combinational step between the input register and the result register
// reset is synchronous and returns the parser to the start of a string prefix
// a held verdict stalls the input only when the byte in the input register
// produces another verdict; other bytes keep flowing
module varint_prefixed_string_check_unit (
   input  logic                              clock,
   input  logic                              reset,
   // input stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] data_byte, [28:8] block_length, [49:29] null_rows, [55:50] zero
   input  logic [vpsc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] first_byte
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] block_ok, [3:1] error_code, [24:4] prefix_count, [31:25] zero
   output logic [vpsc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vpsc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [vpsc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [vpsc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import vpsc_pkg::*;

   // configuration register
   logic nullable_ff;
   logic csr_write;

   // input register
   logic               in_valid_ff;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               in_first_ff;
   logic               in_last_ff;
   logic [CNT_W-1:0]   in_blen_ff;
   logic [CNT_W-1:0]   in_rows_ff;

   // parser state
   logic [PHASE_W-1:0] phase_ff,     phase_in;
   logic [ACC_W-1:0]   acc_ff,       acc_in;
   logic [SHIFT_W-1:0] shift_ff,     shift_in;
   logic [CNT_W-1:0]   skip_ff,      skip_in;
   logic [CNT_W-1:0]   strings_ff,   strings_in;
   logic [CODE_W-1:0]  err_ff,       err_in;
   // bytes of the block not yet consumed, floored at zero
   logic [CNT_W-1:0]   remain_ff,    remain_in;
   // null map bytes not yet consumed
   logic [CNT_W-1:0]   null_left_ff, null_left_in;

   // result register
   logic               out_valid_ff;
   logic               out_ok_ff;
   logic [CODE_W-1:0]  out_code_ff;
   logic [CNT_W-1:0]   out_count_ff;

   // handshake and working values
   logic               active;
   logic               produce;
   logic               advance;
   logic [PHASE_W-1:0] ph_s;
   logic [ACC_W-1:0]   acc_s;
   logic [SHIFT_W-1:0] shift_s;
   logic [CNT_W-1:0]   skip_s;
   logic [CNT_W-1:0]   strings_s;
   logic [CODE_W-1:0]  err_s;
   logic [CNT_W-1:0]   remain_s;
   logic [CNT_W-1:0]   null_s;
   logic [CNT_W-1:0]   remain_dec;
   logic [CNT_W-1:0]   skip_dec;
   logic [ACC_W-1:0]   acc_or;
   logic [SHIFT_W-1:0] shift_next;
   logic [CODE_W-1:0]  code_in;

   // ---------------------------------------------------------------------------
   // configuration port: one register, always ready
   // ---------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_NULLABLE_MODE)
                       ? {{(CSR_DATA_W-1){1'b0}}, nullable_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         nullable_ff <= 1'b0;
      end else if (csr_write && (csr_paddr[2] == REG_NULLABLE_MODE)) begin
         nullable_ff <= csr_pwdata[0];
      end
   end

   // ---------------------------------------------------------------------------
   // handshake: a byte leaves the input register unless it carries a verdict
   // and the result register is still full
   // ---------------------------------------------------------------------------
   // bytes after a verdict are dropped until the next first byte
   assign active     = in_first_ff | (phase_ff != PH_DONE);
   assign produce    = in_valid_ff & in_last_ff & active;
   assign advance    = in_valid_ff & (~produce | ~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata[7:0];
         in_blen_ff  <= req_tdata[28:8];
         in_rows_ff  <= req_tdata[49:29];
         in_first_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
   end

   // ---------------------------------------------------------------------------
   // parser step
   // ---------------------------------------------------------------------------
   always_comb begin
      // a first byte restarts from a fresh block
      if (in_first_ff) begin
         ph_s      = (nullable_ff && (in_rows_ff != '0))
                     ? PH_NULLMAP : PH_PREFIX;
         err_s     = (nullable_ff && (in_blen_ff <= in_rows_ff)) ? E_SHORT : E_OK;
         acc_s     = '0;
         shift_s   = '0;
         skip_s    = '0;
         strings_s = '0;
         remain_s  = in_blen_ff;
         null_s    = in_rows_ff;
      end else begin
         ph_s      = phase_ff;
         err_s     = err_ff;
         acc_s     = acc_ff;
         shift_s   = shift_ff;
         skip_s    = skip_ff;
         strings_s = strings_ff;
         remain_s  = remain_ff;
         null_s    = null_left_ff;
      end

      remain_dec = (remain_s != '0) ? remain_s - 1'b1 : '0;
      skip_dec   = (skip_s != '0) ? skip_s - 1'b1 : '0;
      acc_or     = acc_s | ({{(ACC_W-7){1'b0}}, in_byte_ff[6:0]} << shift_s[5:0]);
      shift_next = shift_s + VARINT_STEP;

      phase_in     = ph_s;
      err_in       = err_s;
      acc_in       = acc_s;
      shift_in     = shift_s;
      skip_in      = skip_s;
      strings_in   = strings_s;
      remain_in    = remain_s;
      null_left_in = null_s;

      // once an error is latched the rest of the block is not parsed
      if (err_s == E_OK) begin
         remain_in = remain_dec;
         unique case (ph_s)
            PH_NULLMAP: begin
               null_left_in = (null_s != '0) ? null_s - 1'b1 : '0;
               if (in_byte_ff > 8'd1) begin
                  err_in = E_NULLMAP;
               end else if (null_s <= 21'd1) begin
                  phase_in = PH_PREFIX;
               end
            end
            PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = PH_PREFIX;
               end
            end
            PH_PREFIX: begin
               if (!in_byte_ff[7]) begin
                  // prefix complete: the string must fit in what is left
                  if ((acc_or[ACC_W-1:CNT_W] != '0) ||
                      (acc_or[CNT_W-1:0] > remain_dec)) begin
                     err_in = E_TOOLONG;
                  end else begin
                     skip_in    = acc_or[CNT_W-1:0];
                     phase_in   = (acc_or[CNT_W-1:0] != '0) ? PH_SKIP : PH_PREFIX;
                     strings_in = (strings_s != CNT_MAX) ? strings_s + 1'b1 : strings_s;
                  end
                  acc_in   = '0;
                  shift_in = '0;
               end else begin
                  acc_in   = acc_or;
                  shift_in = shift_next;
                  if (shift_next >= SHIFT_LIMIT) begin
                     err_in = E_OVERFLOW;
                  end
               end
            end
            PH_DONE: begin
               // not reached while active
            end
         endcase
      end

      // verdict from the state after this byte
      priority if (err_in != E_OK) begin
         code_in = err_in;
      end else if (phase_in == PH_NULLMAP) begin
         code_in = E_SHORT;
      end else if ((phase_in == PH_PREFIX) && (shift_in != '0)) begin
         code_in = E_TRUNC;
      end else if ((phase_in == PH_SKIP) && (skip_in != '0)) begin
         code_in = E_TOOLONG;
      end else if (strings_in == '0) begin
         code_in = E_NOSTR;
      end else begin
         code_in = E_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PREFIX;
         acc_ff       <= '0;
         shift_ff     <= '0;
         skip_ff      <= '0;
         strings_ff   <= '0;
         err_ff       <= E_OK;
         remain_ff    <= '0;
         null_left_ff <= '0;
      end else if (advance && active) begin
         phase_ff     <= in_last_ff ? PH_DONE : phase_in;
         acc_ff       <= acc_in;
         shift_ff     <= shift_in;
         skip_ff      <= skip_in;
         strings_ff   <= strings_in;
         err_ff       <= err_in;
         remain_ff    <= remain_in;
         null_left_ff <= null_left_in;
      end
   end

   // ---------------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && produce) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         out_ok_ff    <= (code_in == E_OK);
         out_code_ff  <= code_in;
         out_count_ff <= strings_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-CNT_W-CODE_W-1){1'b0}}, out_count_ff, out_code_ff, out_ok_ff};

`ifndef SYNTHESIS
   // the ok flag agrees with the code
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ok_ff == (out_code_ff == E_OK)))
      else $error("block_ok disagrees with error_code");

   // no verdict code beyond the defined set
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_code_ff <= E_SHORT))
      else $error("undefined verdict code");

   // the skip phase always has bytes left to skip
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (skip_ff != '0))
      else $error("skip phase with nothing to skip");

   // a healthy prefix never holds a shift past the last payload position
   assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_PREFIX) && (err_ff == E_OK)) |-> (shift_ff < SHIFT_LIMIT))
      else $error("prefix shift out of range without overflow");

   // a stalled byte stays in the input register
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input byte lost while stalled");
`endif

endmodule
